@@ sv/bse_pkg.sv @@
// Package for the bubble sort engine: sequencer state type.
// No dependencies; imported by the top level bubble_sort_engine.
`timescale 1ns / 1ps

package bse_pkg;

  // Sequencer states: list loading, one bubble pass, sorted-list emission.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PASS_INIT,
    ST_PASS_FIRST,
    ST_PASS_RUN,
    ST_PASS_END,
    ST_EMIT_RD,
    ST_EMIT_LD
  } bse_state_t;

endpackage

@@ sv/bse_mem.sv @@
// Element store of the bubble sort engine: one write port, one read port,
// read data registered. No package dependencies.
`timescale 1ns / 1ps

module bse_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/bubble_sort_engine.sv @@
// Top level of the bubble sort engine: load, sort and emit sequencer.
// Depends on bse_pkg (state type) and bse_mem (element store).
`timescale 1ns / 1ps
//
// Channel  Direction  Ports                       Payload
// in_      slave      in_tvalid/tready/tdata/tlast  tdata: value; tlast: last_item
// out_     master     out_tvalid/tready/tdata/tlast/tuser
//                                                 tdata: sorted_value;
//                                                 tlast: last_result; tuser: overflow
//
// Loading accepts one request per cycle. A list of n elements is then
// sorted by bubble passes over prefixes of n down to 2 elements, each pass
// streaming its prefix through the single read port of the store, and then
// emitted one element at a time (read, then load the output register).
// Reset (rst_n, synchronous, active low) clears the sequencer; the store
// needs no clearing pass. Output stalls hold emission; loading of the next
// list starts while the final result still waits in the output register.

module bubble_sort_engine #(
  parameter int MAX_ENTRIES = 64,
  parameter int VALUE_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input channel.
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] in_tdata,  // [VALUE_BITS-1:0] value
  input  logic                                  in_tlast,
  // Result channel.
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((VALUE_BITS + 7) / 8) * 8-1:0] out_tdata, // [VALUE_BITS-1:0] sorted_value
  output logic                                  out_tlast,
  output logic                                  out_tuser  // [0] overflow
);

  import bse_pkg::*;

  localparam int AW  = $clog2(MAX_ENTRIES);
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int TDW = ((VALUE_BITS + 7) / 8) * 8;

  // Sequencer registers.
  bse_state_t            state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [CW-1:0]         span_r, span_nxt;
  logic [AW-1:0]         k_r, k_nxt;
  logic [VALUE_BITS-1:0] carry_r, carry_nxt;
  logic [AW-1:0]         e_r, e_nxt;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  // Store ports.
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [VALUE_BITS-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic                  mem_re;
  logic [VALUE_BITS-1:0] mem_rdata;

  bse_mem #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (VALUE_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Next state, store accesses and output register updates.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    span_nxt      = span_r;
    k_nxt         = k_r;
    carry_nxt     = carry_r;
    e_nxt         = e_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_valid_r;
    in_tready     = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = carry_r;
    mem_raddr     = '0;
    mem_re        = 1'b0;

    // A taken result frees the output register.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          // Store the element while there is room; otherwise drop and flag it.
          if (cnt_r < CW'(MAX_ENTRIES)) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_r[AW-1:0];
            mem_wdata = in_tdata[VALUE_BITS-1:0];
            cnt_nxt   = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            e_nxt = '0;
            if (cnt_nxt >= CW'(2)) begin
              span_nxt  = cnt_nxt;
              state_nxt = ST_PASS_INIT;
            end else begin
              state_nxt = ST_EMIT_RD;
            end
          end
        end
      end

      ST_PASS_INIT: begin
        // Fetch the head of the prefix.
        mem_re    = 1'b1;
        mem_raddr = '0;
        state_nxt = ST_PASS_FIRST;
      end

      ST_PASS_FIRST: begin
        carry_nxt = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = AW'(1);
        k_nxt     = AW'(1);
        state_nxt = ST_PASS_RUN;
      end

      ST_PASS_RUN: begin
        // The larger of carry and element k moves on; the smaller settles at k-1.
        mem_we    = 1'b1;
        mem_waddr = k_r - AW'(1);
        if (carry_r > mem_rdata) begin
          mem_wdata = mem_rdata;
        end else begin
          mem_wdata = carry_r;
          carry_nxt = mem_rdata;
        end
        if (CW'(k_r) == span_r - CW'(1)) begin
          state_nxt = ST_PASS_END;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = k_r + AW'(1);
          k_nxt     = k_r + AW'(1);
        end
      end

      ST_PASS_END: begin
        // The largest element of the prefix lands at its end.
        mem_we    = 1'b1;
        mem_waddr = AW'(span_r - CW'(1));
        mem_wdata = carry_r;
        span_nxt  = span_r - CW'(1);
        if (span_r == CW'(2)) begin
          e_nxt     = '0;
          state_nxt = ST_EMIT_RD;
        end else begin
          state_nxt = ST_PASS_INIT;
        end
      end

      ST_EMIT_RD: begin
        // Read only once the output register will be free.
        if (!out_valid_r || out_tready) begin
          mem_re    = 1'b1;
          mem_raddr = e_r;
          state_nxt = ST_EMIT_LD;
        end
      end

      ST_EMIT_LD: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = mem_rdata;
        out_ovf_nxt   = ovf_r;
        out_last_nxt  = (CW'(e_r) == cnt_r - CW'(1));
        if (CW'(e_r) == cnt_r - CW'(1)) begin
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_LOAD;
        end else begin
          e_nxt     = e_r + AW'(1);
          state_nxt = ST_EMIT_RD;
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and index registers.
  always_ff @(posedge clk) begin
    span_r     <= span_nxt;
    k_r        <= k_nxt;
    carry_r    <= carry_nxt;
    e_r        <= e_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDW'(out_data_r);
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

  // The element count never passes the store capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ENTRIES))
    else $error("element count exceeds store capacity");

  // A pass never walks past the end of its prefix.
  a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PASS_RUN) |-> (CW'(k_r) < span_r && span_r >= CW'(2)))
    else $error("bubble pass index outside prefix");

  // Within a pass the write and the read never hit the same entry.
  a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("store read and write collide");

  // The output register is free whenever a sorted element is loaded into it.
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_LD) |-> !out_valid_r)
    else $error("output register overwritten");

  // After the final result is loaded the block is ready for a new list.
  a_list_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_LD && out_last_nxt) |=> (state_r == ST_LOAD && cnt_r == '0))
    else $error("list state not cleared after emission");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for bubble_sort_engine: loads lists, checks sorted output.
// Depends only on the RTL (bubble_sort_engine and what it instantiates).
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_ENTRIES  = 64;
  localparam int VALUE_BITS   = 16;
  localparam int DATA_W       = ((VALUE_BITS + 7) / 8) * 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 5000;
  localparam int DRAIN_CYCLES = 400;
  localparam int RANDOM_ITEMS = 460;
  localparam int DIRECTED_N   = 25;

  // One expected sorted word on the result channel.
  typedef struct {
    logic [VALUE_BITS-1:0] value;
    logic                  last;
    logic                  ovf;
  } sorted_word_t;

  // One row of the directed table. Rows marked typed close a one-element
  // list whose single result is written out here.
  typedef struct {
    logic [VALUE_BITS-1:0] value;
    bit                    last;
    bit                    typed;
    logic [VALUE_BITS-1:0] exp_value;
  } list_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  logic              in_tlast = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  logic              out_tlast;
  logic              out_tuser;

  // Predictor state: its own copy of the element store.
  logic [VALUE_BITS-1:0] held_store [MAX_ENTRIES];
  int                    held_count = 0;
  bit                    dropped_seen = 1'b0;
  sorted_word_t          pending_sorted [$];

  int unsigned cycle_count = 0;
  int unsigned fault_count = 0;
  int unsigned results_checked = 0;
  int unsigned lists_closed = 0;
  int unsigned overflow_lists = 0;
  int          longest_list = 0;
  int unsigned hold_stall_cycles = 0;
  int          burst_left = 0;
  bit          hold_pending = 1'b0;
  bit          hold_active = 1'b0;

  list_row_t directed_rows [DIRECTED_N];

  bubble_sort_engine #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .VALUE_BITS  (VALUE_BITS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [15:0] value
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [15:0] sorted_value
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)   // [0] overflow
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bubble_sort_engine test failed");
      $finish;
    end
  end

  // Load one element into the predicted store; when it closes the list,
  // bubble-sort the held prefix and queue one expected word per element.
  function automatic void take_element(input logic [VALUE_BITS-1:0] v, input bit closes,
                                       input bit record);
    sorted_word_t          w;
    int                    span;
    int                    k;
    logic [VALUE_BITS-1:0] swap_word;
    if (held_count < MAX_ENTRIES) begin
      held_store[held_count] = v;
      held_count++;
    end else begin
      dropped_seen = 1'b1;
    end
    if (!closes) return;
    lists_closed++;
    if (dropped_seen) overflow_lists++;
    if (held_count > longest_list) longest_list = held_count;
    for (span = held_count; span > 1; span--) begin
      for (k = 0; k + 1 < span; k++) begin
        if (held_store[k] > held_store[k + 1]) begin
          swap_word         = held_store[k];
          held_store[k]     = held_store[k + 1];
          held_store[k + 1] = swap_word;
        end
      end
    end
    if (record) begin
      for (k = 0; k < held_count; k++) begin
        w.value = held_store[k];
        w.last  = (k + 1 == held_count);
        w.ovf   = dropped_seen;
        pending_sorted.push_back(w);
      end
    end
    held_count   = 0;
    dropped_seen = 1'b0;
  endfunction

  // Offer one request on the input channel, in bursts with random gaps,
  // and return at the rising edge where it is accepted.
  task automatic send_item(input logic [VALUE_BITS-1:0] v, input bit last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        in_tdata  <= DATA_W'($urandom);
        in_tlast  <= 1'($urandom_range(0, 1));
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= DATA_W'(v);
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // Pick a list element according to the value style of the list.
  function automatic logic [VALUE_BITS-1:0] pick_value(input int style);
    case (style)
      0:       return VALUE_BITS'($urandom_range(0, 65535));
      1:       return VALUE_BITS'($urandom_range(0, 3));
      2: begin
        case ($urandom_range(0, 2))
          0:       return '0;
          1:       return '1;
          default: return VALUE_BITS'($urandom);
        endcase
      end
      default: return VALUE_BITS'(16'hFFF0 + $urandom_range(0, 15));
    endcase
  endfunction

  // Send a whole list of random content and track it in the predictor.
  task automatic send_list(input int len, output int sent);
    int                    style;
    int                    k;
    logic [VALUE_BITS-1:0] v;
    style = $urandom_range(0, 3);
    for (k = 0; k < len; k++) begin
      v = pick_value(style);
      send_item(v, k == len - 1);
      take_element(v, k == len - 1, 1'b1);
    end
    sent = len;
  endtask

  // Result checker: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    sorted_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_sorted.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected result: value=%h last=%b ovf=%b", out_tdata[VALUE_BITS-1:0],
                   out_tlast, out_tuser);
      end else begin
        w = pending_sorted.pop_front();
        results_checked++;
        if (out_tdata !== DATA_W'(w.value) || out_tlast !== w.last || out_tuser !== w.ovf) begin
          fault_count++;
          if (fault_count <= 10)
            $display("result mismatch: expected value=%h last=%b ovf=%b, got value=%h last=%b ovf=%b",
                     w.value, w.last, w.ovf, out_tdata[VALUE_BITS-1:0], out_tlast, out_tuser);
        end
      end
    end
    if (hold_active && in_tvalid && !in_tready) hold_stall_cycles++;
  end

  // Result receiver: stretches of steady, random and mostly-stalled ready,
  // with one long hold-off when the stimulus asks for it.
  initial begin
    int mode;
    int len;
    int i;
    int held;
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      if (hold_pending && !hold_done) begin
        hold_done   = 1'b1;
        hold_active = 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) begin
          @(negedge clk);
          out_tready <= 1'b0;
        end
        hold_active = 1'b0;
      end else begin
        mode = $urandom_range(0, 2);
        len  = $urandom_range(20, 200);
        for (i = 0; i < len && (hold_done || !hold_pending); i++) begin
          @(negedge clk);
          case (mode)
            0:       out_tready <= 1'b1;
            1:       out_tready <= 1'($urandom_range(0, 1));
            default: out_tready <= ($urandom_range(0, 7) == 0);
          endcase
        end
      end
    end
  end

  // Main stimulus: reset, directed table, then random lists.
  initial begin
    int           r;
    int           sent;
    int           random_sent;
    int           len;
    int           pick;
    sorted_word_t w;

    directed_rows = '{
      '{16'h0000, 1'b1, 1'b1, 16'h0000},  // one-element list, all zeros
      '{16'hFFFF, 1'b1, 1'b1, 16'hFFFF},  // one-element list, all ones
      '{16'h8000, 1'b1, 1'b1, 16'h8000},  // one-element list, top bit only
      '{16'hFFFF, 1'b0, 1'b0, 16'h0000},  // reversed pair of extremes
      '{16'h0000, 1'b1, 1'b0, 16'h0000},
      '{16'h0001, 1'b0, 1'b0, 16'h0000},  // ties are kept in place
      '{16'h0001, 1'b0, 1'b0, 16'h0000},
      '{16'h0000, 1'b1, 1'b0, 16'h0000},
      '{16'hFFFF, 1'b0, 1'b0, 16'h0000},  // strictly descending list
      '{16'hC000, 1'b0, 1'b0, 16'h0000},
      '{16'h8000, 1'b0, 1'b0, 16'h0000},
      '{16'h4000, 1'b0, 1'b0, 16'h0000},
      '{16'h0001, 1'b1, 1'b0, 16'h0000},
      '{16'h0000, 1'b0, 1'b0, 16'h0000},  // already sorted list
      '{16'h0001, 1'b0, 1'b0, 16'h0000},
      '{16'h0002, 1'b0, 1'b0, 16'h0000},
      '{16'h7FFF, 1'b0, 1'b0, 16'h0000},
      '{16'hFFFF, 1'b1, 1'b0, 16'h0000},
      '{16'hAAAA, 1'b0, 1'b0, 16'h0000},  // alternating patterns with repeats
      '{16'h5555, 1'b0, 1'b0, 16'h0000},
      '{16'hAAAA, 1'b0, 1'b0, 16'h0000},
      '{16'h5555, 1'b0, 1'b0, 16'h0000},
      '{16'h0000, 1'b1, 1'b0, 16'h0000},
      '{16'h1234, 1'b0, 1'b0, 16'h0000},  // pair of equal values
      '{16'h1234, 1'b1, 1'b0, 16'h0000}
    };

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table: typed rows carry their own single result.
    for (r = 0; r < DIRECTED_N; r++) begin
      send_item(directed_rows[r].value, directed_rows[r].last);
      take_element(directed_rows[r].value, directed_rows[r].last, !directed_rows[r].typed);
      if (directed_rows[r].typed) begin
        w.value = directed_rows[r].exp_value;
        w.last  = 1'b1;
        w.ovf   = 1'b0;
        pending_sorted.push_back(w);
      end
    end

    // Random part opens with a full store and an overflowing list, while
    // the receiver holds off so the block backs up into its input.
    hold_pending = 1'b1;
    random_sent  = 0;
    send_list(MAX_ENTRIES, sent);
    random_sent += sent;
    send_list(MAX_ENTRIES + 3, sent);
    random_sent += sent;
    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      len = $urandom_range(1, 12);
      else if (pick < 90) len = $urandom_range(13, 40);
      else if (pick < 97) len = $urandom_range(41, MAX_ENTRIES);
      else                len = $urandom_range(MAX_ENTRIES + 1, MAX_ENTRIES + 8);
      send_list(len, sent);
      random_sent += sent;
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    // Drain: every expected result must arrive, then nothing more.
    while (pending_sorted.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d lists (%0d over capacity, longest %0d loaded), %0d results checked.",
             lists_closed, overflow_lists, longest_list, results_checked);
    $display("Receiver hold-off of %0d cycles stalled the input for %0d cycles.",
             HOLD_CYCLES, hold_stall_cycles);
    if (fault_count == 0) begin
      $display("bubble_sort_engine test passed");
    end else begin
      $display("%0d result faults found.", fault_count);
      $display("bubble_sort_engine test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/bse_pkg.sv
sv/bse_mem.sv
sv/bubble_sort_engine.sv
dv/testbench.sv
